[src/tns_pkg.sv]
`default_nettype none
package tns_pkg;

  // field widths
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned BASE_W     = 32;
  localparam int unsigned DIV_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // defaults
  localparam int unsigned   NOTES_DEFAULT = 64;
  localparam logic [GAP_W-1:0]  GAP_RESET  = GAP_W'(40);
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(1193180);
  localparam logic [DIV_W-1:0]  DIV_MAX    = {DIV_W{1'b1}};

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_START = 2'd2,
    KIND_STOP  = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_TICKS  = 2'd0,
    CFG_BASE_CLOCK = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NOW_W-1:0]  now_ticks;
    logic [SLOT_W-1:0] note_slot;
    logic [FREQ_W-1:0] note_frequency;
    logic [DUR_W-1:0]  note_duration;
    logic [LEN_W-1:0]  song_length;
    logic              loop_enable;
  } in_word_t;

  typedef struct packed {
    logic              speaker_on;
    logic [DIV_W-1:0]  tone_divisor;
    logic              playing;
    logic [LEN_W-1:0]  next_note;
    logic              in_note;
  } out_word_t;

  // one table entry
  typedef struct packed {
    logic [FREQ_W-1:0] pitch;
    logic [DUR_W-1:0]  length;
  } note_t;

endpackage
`default_nettype wire

[src/tns_if.sv]
`default_nettype none
// input word channel
interface tns_in_if import tns_pkg::*;;
  logic     valid;
  logic     ready;
  in_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// result word channel
interface tns_out_if import tns_pkg::*;;
  logic      valid;
  logic      ready;
  out_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// register write channel
interface tns_cfg_if import tns_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[src/tns_note_ram.sv]
`default_nettype none
module tns_note_ram import tns_pkg::*; #(
  parameter int unsigned DEPTH = NOTES_DEFAULT
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire note_t                               wdata_i,
  input  wire logic                                re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output note_t                                    rdata_o
);

  note_t mem [DEPTH];
  note_t rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[src/tns_divider.sv]
`default_nettype none
module tns_divider import tns_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [BASE_W-1:0] dividend_i,
  input  wire logic [FREQ_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [BASE_W-1:0]      quotient_o
);

  localparam int unsigned CntW = $clog2(BASE_W);
  localparam logic [CntW-1:0] LastStep = CntW'(BASE_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [BASE_W-1:0] num_q;
  logic [FREQ_W-1:0] rem_q;
  logic [FREQ_W-1:0] den_q;

  logic [FREQ_W:0]   trial;
  logic [FREQ_W:0]   diff;
  logic              fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, num_q[BASE_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[BASE_W-2:0], fits};
      rem_q <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule
`default_nettype wire

[src/tone_note_sequencer.sv]
// channel  | dir | handshake     | word
// ---------+-----+---------------+---------------------------------------------
// in_i     | in  | valid / ready | kind, now, slot, frequency, duration, length
// out_o    | out | valid / ready | speaker_on, divisor, playing, next_note, in_note
// cfg_i    | in  | valid / ready | register index and write data, always ready
//
// one item at a time; load, start, stop and idle, early or ending ticks pass
// through exec and emit; a tick that starts a sounding note adds a table read and a
// 32-step shift-subtract divide of the base clock by the note frequency, a rest
// note only the table read; the result register lets the next word in while a
// result waits; reset clears all control state; the note table holds no reset
// and the user must load each entry it reads, which the block does not enforce
`default_nettype none
module tone_note_sequencer import tns_pkg::*; #(
  parameter int unsigned MAX_NOTES = NOTES_DEFAULT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tns_in_if.sink     in_i,
  tns_out_if.source  out_o,
  tns_cfg_if.sink    cfg_i
);

  localparam int unsigned AddrW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DIV,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  in_word_t          item_q, item_d;
  logic [GAP_W-1:0]  gap_q, gap_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic [LEN_W-1:0]  ptr_q, ptr_d;
  logic [NOW_W-1:0]  deadline_q, deadline_d;
  logic [LEN_W-1:0]  size_q, size_d;
  logic              repeat_q, repeat_d;
  logic              running_q, running_d;
  logic              phase_q, phase_d;
  logic              gate_q, gate_d;
  logic [DIV_W-1:0]  divisor_q, divisor_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, out_word_d;

  logic              mem_we;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  note_t             mem_wdata;
  note_t             mem_rdata;
  logic              div_start;
  logic              div_done;
  logic [BASE_W-1:0] div_quot;

  logic [NOW_W-1:0]  since;
  logic [LEN_W-1:0]  idx;

  assign mem_wdata = '{pitch: item_q.note_frequency, length: item_q.note_duration};

  tns_note_ram #(
    .DEPTH (MAX_NOTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(item_q.note_slot)),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tns_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (base_q),
    .divisor_i  (mem_rdata.pitch),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;

  // time since deadline, negative means early
  assign since = item_q.now_ticks - deadline_q;
  // note to start, wrapping to the first one past the end
  assign idx   = (ptr_q >= size_q) ? '0 : ptr_q;
  assign mem_raddr = AddrW'(idx);

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    gap_d       = gap_q;
    base_d      = base_q;
    ptr_d       = ptr_q;
    deadline_d  = deadline_q;
    size_d      = size_q;
    repeat_d    = repeat_q;
    running_d   = running_q;
    phase_d     = phase_q;
    gate_d      = gate_q;
    divisor_d   = divisor_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    div_start   = 1'b0;

    // register writes
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_GAP_TICKS:  gap_d  = cfg_i.data[GAP_W-1:0];
        CFG_BASE_CLOCK: base_d = cfg_i.data[BASE_W-1:0];
        default: ;
      endcase
    end

    // result word taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          item_d  = in_i.word;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_EMIT;
        unique case (kind_e'(item_q.kind))
          KIND_TICK: begin
            if (running_q && !since[NOW_W-1]) begin
              if (phase_q) begin
                // note over, start the gap
                gate_d     = 1'b0;
                phase_d    = 1'b0;
                deadline_d = item_q.now_ticks + NOW_W'(gap_q);
              end else if ((ptr_q >= size_q) && !repeat_q) begin
                // end of song
                running_d = 1'b0;
                phase_d   = 1'b0;
                ptr_d     = '0;
                gate_d    = 1'b0;
              end else begin
                ptr_d   = idx;
                mem_re  = 1'b1;
                state_d = S_READ;
              end
            end
          end
          KIND_LOAD: begin
            if (32'(item_q.note_slot) < MAX_NOTES) begin
              mem_we = 1'b1;
            end
          end
          KIND_START: begin
            if (item_q.song_length != '0) begin
              size_d     = (32'(item_q.song_length) > MAX_NOTES) ?
                           LEN_W'(MAX_NOTES) : item_q.song_length;
              repeat_d   = item_q.loop_enable;
              ptr_d      = '0;
              deadline_d = item_q.now_ticks;
              running_d  = 1'b1;
              phase_d    = 1'b0;
            end
          end
          KIND_STOP: begin
            running_d = 1'b0;
            phase_d   = 1'b0;
            ptr_d     = '0;
            gate_d    = 1'b0;
          end
          default: ;
        endcase
      end

      S_READ: begin
        deadline_d = item_q.now_ticks + NOW_W'(mem_rdata.length);
        ptr_d      = ptr_q + 1'b1;
        phase_d    = 1'b1;
        if (mem_rdata.pitch == '0) begin
          // rest: gate closes, divisor kept
          gate_d  = 1'b0;
          state_d = S_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          if (div_quot == '0) begin
            divisor_d = DIV_W'(1);
          end else if (div_quot[BASE_W-1:DIV_W] != '0) begin
            divisor_d = DIV_MAX;
          end else begin
            divisor_d = div_quot[DIV_W-1:0];
          end
          gate_d  = 1'b1;
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_word_d  = '{speaker_on:   gate_q,
                          tone_divisor: divisor_q,
                          playing:      running_q,
                          next_note:    ptr_q,
                          in_note:      phase_q};
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gap_q       <= GAP_RESET;
      base_q      <= BASE_RESET;
      ptr_q       <= '0;
      deadline_q  <= '0;
      size_q      <= '0;
      repeat_q    <= 1'b0;
      running_q   <= 1'b0;
      phase_q     <= 1'b0;
      gate_q      <= 1'b0;
      divisor_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gap_q       <= gap_d;
      base_q      <= base_d;
      ptr_q       <= ptr_d;
      deadline_q  <= deadline_d;
      size_q      <= size_d;
      repeat_q    <= repeat_d;
      running_q   <= running_d;
      phase_q     <= phase_d;
      gate_q      <= gate_d;
      divisor_q   <= divisor_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_word_q <= out_word_d;
  end

endmodule
`default_nettype wire

[src/tns_checker.sv]
`default_nettype none
module tns_checker import tns_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_word
);

  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // no result without an accepted word, at most two in flight
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pend_q != 2'd0 && pend_q != 2'd3)
    else $error("result word without matching input word");

  // sound and note phase only while the sequence runs
  a_sound_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_word.speaker_on || out_word.in_note) |-> out_word.playing)
    else $error("speaker or note phase active while stopped");

  // a stopped sequence sits at the first note
  a_stopped_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_word.playing |-> out_word.next_note == '0)
    else $error("note pointer not cleared while stopped");

endmodule

bind tone_note_sequencer tns_checker u_tns_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_word  (out_o.word)
);
`default_nettype wire
